// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check b in the same cycle as a.
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Check b in the cycle after a.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== design/lsbx_pkg.sv =====
package lsbx_pkg;

    localparam logic [7:0] TERM_RESET = 8'd35;

    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic       KIND_BYTE   = 1'b0;
    localparam logic       KIND_LENGTH = 1'b1;

    localparam logic [31:0] LEN_W1 = 32'd100;
    localparam logic [31:0] LEN_W2 = 32'd10000;

    typedef struct packed {
        logic       first_pixel;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [31:0] msg_length;
        logic        run_end;
    } result_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [31:0] msg_length;
    } entry_t;

    typedef struct packed {
        logic [6:0]  residual_bits;
        logic [2:0]  residual_count;
        logic [1:0]  phase;
        logic        held_terminator;
        logic [1:0]  length_index;
        logic [31:0] length_sum;
    } state_t;

    localparam state_t ST_RESET = '{
        residual_bits:   7'd0,
        residual_count:  3'd0,
        phase:           PH_SEARCH,
        held_terminator: 1'b0,
        length_index:    2'd0,
        length_sum:      32'd0
    };

    typedef struct packed {
        state_t     st;
        logic [1:0] cnt;
        entry_t     e0;
        entry_t     e1;
    } byte_res_t;

    function automatic byte_res_t take_byte(state_t s, logic [7:0] d, logic [7:0] term);
        byte_res_t   r;
        logic [31:0] v;
        logic [31:0] p;
        logic [31:0] sum;
        r     = '0;
        r.st  = s;
        v     = {{24{d[7]}}, d};
        p     = v;
        sum   = '0;
        unique case (s.phase)
            PH_SEARCH:
            begin
                if (d == term)
                begin
                    if (s.held_terminator)
                    begin
                        r.st.held_terminator = 1'b0;
                        r.st.phase           = PH_LENGTH;
                        r.st.length_index    = 2'd0;
                        r.st.length_sum      = 32'd0;
                    end
                    else
                    begin
                        r.st.held_terminator = 1'b1;
                    end
                end
                else if (s.held_terminator)
                begin
                    r.e0 = '{kind: KIND_BYTE, data_byte: term, msg_length: 32'd0};
                    r.e1 = '{kind: KIND_BYTE, data_byte: d, msg_length: 32'd0};
                    r.cnt = 2'd2;
                    r.st.held_terminator = 1'b0;
                end
                else
                begin
                    r.e0 = '{kind: KIND_BYTE, data_byte: d, msg_length: 32'd0};
                    r.cnt = 2'd1;
                end
            end
            PH_LENGTH:
            begin
                case (s.length_index)
                    2'd0:    p = v;
                    2'd1:    p = v * LEN_W1;
                    default: p = v * LEN_W2;
                endcase
                sum = s.length_sum + p;
                r.st.length_sum = sum;
                if (s.length_index[1])
                begin
                    r.e0 = '{kind: KIND_LENGTH, data_byte: 8'd0, msg_length: sum};
                    r.cnt = 2'd1;
                    r.st.phase        = PH_DONE;
                    r.st.length_index = 2'd0;
                end
                else
                begin
                    r.st.length_index = s.length_index + 2'd1;
                end
            end
            default:
            begin
                r.st = s;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== design/lsb_stego_byte_extractor.sv =====
// Pixels enter on pix in raster order, nine hidden bits each; recovered message bytes and the
// final length word leave on res, with run_end marking the last result of a pixel. A pixel is
// decoded combinationally from the input register and enters the result buffer when that is
// empty or gives up its last result; its up to three results leave the single result port one
// per cycle while res_ready is high; the stream runs at one pixel per cycle while pixels give
// at most one result each with res_ready high. Terminator resets to 35; cfg_wr_en writes it.
`include "assert_macros.svh"

module lsb_stego_byte_extractor (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    output logic                 pix_ready,
    input  lsbx_pkg::pixel_t     pix,
    output logic                 res_valid,
    input  logic                 res_ready,
    output lsbx_pkg::result_t    res,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data
);

    logic                        in_full_reg;
    lsbx_pkg::pixel_t            pix_reg;
    lsbx_pkg::state_t            st_reg;
    lsbx_pkg::state_t            st_next;
    logic [7:0]                  term_reg;
    logic [1:0]                  buf_cnt_reg;
    logic [1:0]                  buf_cnt_next;
    lsbx_pkg::entry_t [2:0]      slot_reg;
    lsbx_pkg::entry_t [2:0]      slot_next;
    lsbx_pkg::entry_t [2:0]      unp_slots;
    logic [1:0]                  unp_cnt;
    logic                        advance;
    logic                        res_take;
    logic                        done_pix;

    lsbx_unpack u_unpack (
        .st         (st_reg),
        .px         (pix_reg),
        .terminator (term_reg),
        .st_next    (st_next),
        .slots      (unp_slots),
        .cnt        (unp_cnt)
    );

    assign res_take  = res_valid && res_ready;
    assign advance   = in_full_reg &&
                       (buf_cnt_reg == 2'd0 || (buf_cnt_reg == 2'd1 && res_ready));
    assign pix_ready = !in_full_reg || advance;

    assign res_valid      = (buf_cnt_reg != 2'd0);
    assign res.kind       = slot_reg[0].kind;
    assign res.data_byte  = slot_reg[0].data_byte;
    assign res.msg_length = slot_reg[0].msg_length;
    assign res.run_end    = (buf_cnt_reg == 2'd1);

    assign done_pix = advance && !pix_reg.first_pixel && st_reg.phase == lsbx_pkg::PH_DONE;

    always_comb
    begin
        buf_cnt_next = buf_cnt_reg;
        slot_next    = slot_reg;
        if (advance)
        begin
            buf_cnt_next = unp_cnt;
            slot_next    = unp_slots;
        end
        else if (res_take)
        begin
            buf_cnt_next = buf_cnt_reg - 2'd1;
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            st_reg      <= lsbx_pkg::ST_RESET;
            term_reg    <= lsbx_pkg::TERM_RESET;
            buf_cnt_reg <= 2'd0;
        end
        else
        begin
            if (pix_valid && pix_ready)
            begin
                in_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_full_reg <= 1'b0;
            end
            if (advance)
            begin
                st_reg <= st_next;
            end
            if (cfg_wr_en)
            begin
                term_reg <= cfg_wr_data;
            end
            buf_cnt_reg <= buf_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_valid && pix_ready)
        begin
            pix_reg <= pix;
        end
        slot_reg <= slot_next;
    end

    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_full_reg && !advance, in_full_reg)
    `ASSERT_IMPL(a_done_quiet, clk, rst_n, done_pix, unp_cnt == 2'd0)
    `ASSERT_NEXT(a_buf_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res))

endmodule

// ===== design/lsbx_unpack.sv =====
module lsbx_unpack (
    input  lsbx_pkg::state_t        st,
    input  lsbx_pkg::pixel_t        px,
    input  logic [7:0]              terminator,
    output lsbx_pkg::state_t        st_next,
    output lsbx_pkg::entry_t [2:0]  slots,
    output logic [1:0]              cnt
);

    lsbx_pkg::state_t    st0;
    lsbx_pkg::byte_res_t ra;
    lsbx_pkg::byte_res_t rb;
    logic [15:0]         acc;
    logic [3:0]          sh;
    logic [7:0]          byte1;
    logic                two;
    logic [1:0]          cnt_b;
    logic [6:0]          mask;

    assign st0   = px.first_pixel ? lsbx_pkg::ST_RESET : st;
    assign acc   = {st0.residual_bits,
                    px.blue[0], px.blue[1], px.blue[2],
                    px.green[0], px.green[1], px.green[2],
                    px.red[0], px.red[1], px.red[2]};
    assign sh    = {1'b0, st0.residual_count} + 4'd1;
    assign byte1 = 8'(acc >> sh);
    assign two   = (st0.residual_count == 3'd7);
    assign mask  = ~(7'h7F << sh);

    assign ra    = lsbx_pkg::take_byte(st0, byte1 ^ 8'h80, terminator);
    assign rb    = lsbx_pkg::take_byte(ra.st, acc[7:0] ^ 8'h80, terminator);
    assign cnt_b = two ? rb.cnt : 2'd0;

    always_comb
    begin
        st_next = st0;
        slots   = '0;
        cnt     = 2'd0;
        if (st0.phase == lsbx_pkg::PH_SEARCH || st0.phase == lsbx_pkg::PH_LENGTH)
        begin
            st_next = two ? rb.st : ra.st;
            cnt     = ra.cnt + cnt_b;
            case (ra.cnt)
                2'd2:
                begin
                    slots[0] = ra.e0;
                    slots[1] = ra.e1;
                    slots[2] = rb.e0;
                end
                2'd1:
                begin
                    slots[0] = ra.e0;
                    slots[1] = rb.e0;
                    slots[2] = rb.e1;
                end
                default:
                begin
                    slots[0] = rb.e0;
                    slots[1] = rb.e1;
                end
            endcase
            if (st_next.phase == lsbx_pkg::PH_DONE || two)
            begin
                st_next.residual_bits  = 7'd0;
                st_next.residual_count = 3'd0;
            end
            else
            begin
                st_next.residual_bits  = acc[6:0] & mask;
                st_next.residual_count = sh[2:0];
            end
        end
    end

endmodule
